/* sv/gcrste_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gcrste_pkg;

	// Fixed byte values of the track format.
	localparam logic [7:0] SYNC_BYTE   = 8'hFF;
	localparam logic [7:0] GAP_BYTE    = 8'h55;
	localparam logic [7:0] HEADER_MARK = 8'h08;
	localparam logic [7:0] DATA_MARK   = 8'h07;
	localparam logic [7:0] HEADER_TAIL = 8'h0F;

	// Reset values of the configuration registers.
	localparam logic [7:0] TRACK_RESET = 8'h01;
	localparam logic [7:0] ID_RESET    = 8'h30;

	// Run lengths, as byte counts.
	localparam int SYNC_COUNT       = 5;
	localparam int GROUP_BYTES      = 5;
	localparam int HEADER_GAP_COUNT = 9;
	localparam int DATA_GAP_COUNT   = 7;
	localparam int HDR_LEN  = 2 * SYNC_COUNT + 2 * GROUP_BYTES + HEADER_GAP_COUNT;
	localparam int GRP_LEN  = GROUP_BYTES;
	localparam int TAIL_LEN = GROUP_BYTES + DATA_GAP_COUNT;
	localparam int IDX_W    = $clog2(HDR_LEN);

	// Default depth of the job queue between the front and the back.
	localparam int QUEUE_DEPTH_DEF = 2;

	// Configuration register indexes.
	localparam logic [1:0] REG_TRACK  = 2'd0;
	localparam logic [1:0] REG_ID_ONE = 2'd1;
	localparam logic [1:0] REG_ID_TWO = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] sector_number;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_HDR  = 2'd0,
		JOB_GRP  = 2'd1,
		JOB_TAIL = 2'd2
	} job_kind_t;

	// One unit of output work: a sector header, a data group or the final group.
	typedef struct packed {
		job_kind_t   kind;
		logic [31:0] word0;
		logic [31:0] word1;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic busy;
		logic on_last;
	} back_stat_t;

	// Standard 1541 nibble code.
	function automatic logic [4:0] gcr_nibble(input logic [3:0] nib);
		logic [4:0] code;
		unique case (nib)
			4'h0: code = 5'h0A;
			4'h1: code = 5'h0B;
			4'h2: code = 5'h12;
			4'h3: code = 5'h13;
			4'h4: code = 5'h0E;
			4'h5: code = 5'h0F;
			4'h6: code = 5'h16;
			4'h7: code = 5'h17;
			4'h8: code = 5'h09;
			4'h9: code = 5'h19;
			4'hA: code = 5'h1A;
			4'hB: code = 5'h1B;
			4'hC: code = 5'h0D;
			4'hD: code = 5'h1D;
			4'hE: code = 5'h1E;
			default: code = 5'h15;
		endcase
		return code;
	endfunction

	// Code four raw bytes, first byte highest, into 40 bits, first code highest.
	function automatic logic [39:0] gcr_encode(input logic [31:0] raw);
		logic [39:0] bits;
		for (int i = 0; i < 8; i++) begin
			bits[39 - 5 * i -: 5] = gcr_nibble(raw[31 - 4 * i -: 4]);
		end
		return bits;
	endfunction

endpackage

`default_nettype wire

/* sv/gcrste_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcrste_front import gcrste_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire logic [7:0] track_number,
	input  wire logic [7:0] disk_id_one,
	input  wire logic [7:0] disk_id_two,
	input  wire logic     queue_full,
	output logic          push,
	output job_t          push_job
);

	logic [7:0]  byte_position_q;
	logic [23:0] pending_raw_q;
	logic [7:0]  running_xor_q;

	logic        accept;
	logic        first;
	logic [7:0]  xor_base;
	logic [7:0]  xor_next;
	logic [23:0] pend_base;
	logic [7:0]  chk;
	logic        is_tail;
	logic        is_group;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Classify the byte by its place in the sector.
	assign first     = (byte_position_q == 8'd0);
	assign is_tail   = (byte_position_q == 8'hFF);
	assign is_group  = (byte_position_q[1:0] == 2'd2);
	assign xor_base  = first ? 8'h00 : running_xor_q;
	assign xor_next  = xor_base ^ in_data.data_byte;
	assign pend_base = first ? {16'h0000, DATA_MARK} : pending_raw_q;
	assign chk       = track_number ^ in_data.sector_number ^ disk_id_one ^ disk_id_two;

	// Build the job for this byte, if it causes any output.
	always_comb begin
		push     = 1'b0;
		push_job = '{kind: JOB_GRP, word0: {pend_base, in_data.data_byte}, word1: 32'h0};
		if (first) begin
			push     = accept;
			push_job = '{kind: JOB_HDR,
				word0: {HEADER_MARK, chk, in_data.sector_number, track_number},
				word1: {disk_id_two, disk_id_one, HEADER_TAIL, HEADER_TAIL}};
		end else if (is_tail) begin
			push     = accept;
			push_job = '{kind: JOB_TAIL, word0: {in_data.data_byte, xor_next, 16'h0000},
				word1: 32'h0};
		end else if (is_group) begin
			push = accept;
		end
	end

	// Sector position, checksum and partial group.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= 8'd0;
			pending_raw_q   <= 24'h0;
			running_xor_q   <= 8'h00;
		end else if (accept) begin
			byte_position_q <= byte_position_q + 8'd1;
			running_xor_q   <= xor_next;
			if (is_tail || is_group) begin
				pending_raw_q <= 24'h0;
			end else begin
				pending_raw_q <= {pend_base[15:0], in_data.data_byte};
			end
		end
	end

endmodule

`default_nettype wire

/* sv/gcrste_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcrste_queue import gcrste_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/gcrste_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module gcrste_back import gcrste_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic queue_empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_data,
	output back_stat_t stat
);

	localparam logic [IDX_W-1:0] HDR_CODE0 = IDX_W'(SYNC_COUNT);
	localparam logic [IDX_W-1:0] HDR_CODE1 = IDX_W'(SYNC_COUNT + GROUP_BYTES);
	localparam logic [IDX_W-1:0] HDR_GAP   = IDX_W'(SYNC_COUNT + 2 * GROUP_BYTES);
	localparam logic [IDX_W-1:0] HDR_SYNC  = IDX_W'(SYNC_COUNT + 2 * GROUP_BYTES
		+ HEADER_GAP_COUNT);
	localparam logic [IDX_W-1:0] GRP_END   = IDX_W'(GROUP_BYTES);

	logic             busy_q;
	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             adv;
	logic             load;
	logic [IDX_W-1:0] last_idx;
	logic [31:0]      word;
	logic [IDX_W-1:0] code_idx;
	logic [39:0]      code;
	logic [7:0]       code_byte;
	logic [7:0]       next_byte;

	assign adv      = !out_valid_q || out_ready;
	assign stat.busy    = busy_q;
	assign stat.on_last = busy_q && (idx_q == last_idx);
	assign load     = !queue_empty && (!busy_q || (adv && stat.on_last));
	assign pop      = load;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Length of the current job.
	always_comb begin
		unique case (job_q.kind)
			JOB_HDR:  last_idx = IDX_W'(HDR_LEN - 1);
			JOB_TAIL: last_idx = IDX_W'(TAIL_LEN - 1);
			default:  last_idx = IDX_W'(GRP_LEN - 1);
		endcase
	end

	// Pick the raw word and code byte for this position.
	always_comb begin
		word     = job_q.word0;
		code_idx = idx_q;
		if (job_q.kind == JOB_HDR) begin
			if (idx_q >= HDR_CODE1) begin
				word     = job_q.word1;
				code_idx = idx_q - HDR_CODE1;
			end else begin
				code_idx = idx_q - HDR_CODE0;
			end
		end
	end

	assign code = gcr_encode(word);

	always_comb begin
		case (code_idx[2:0])
			3'd0:    code_byte = code[39:32];
			3'd1:    code_byte = code[31:24];
			3'd2:    code_byte = code[23:16];
			3'd3:    code_byte = code[15:8];
			default: code_byte = code[7:0];
		endcase
	end

	// Output byte for the current position of the job.
	always_comb begin
		unique case (job_q.kind)
			JOB_HDR: begin
				if (idx_q < HDR_CODE0) begin
					next_byte = SYNC_BYTE;
				end else if (idx_q < HDR_GAP) begin
					next_byte = code_byte;
				end else if (idx_q < HDR_SYNC) begin
					next_byte = GAP_BYTE;
				end else begin
					next_byte = SYNC_BYTE;
				end
			end
			JOB_TAIL: begin
				next_byte = (idx_q < GRP_END) ? code_byte : GAP_BYTE;
			end
			default: next_byte = code_byte;
		endcase
	end

	// Job register and position counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && adv) begin
			if (stat.on_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= head;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			out_data_q <= '{out_byte: next_byte, last_of_run: stat.on_last};
		end
	end

endmodule

`default_nettype wire

/* sv/gcr_sector_track_encoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload      Handshake
// in        input      in_item_t    in_valid / in_ready
// out       output     out_item_t   out_valid / out_ready
// config    input      32-bit APB   psel / penable / pwrite, pready tied high
//
// The front takes one data byte per cycle while the job queue has room and
// hands each header or group job to the back. The back sends one track byte
// per cycle from its output register while out_ready is high and it has a job;
// a sector gives 361 track bytes for 256 data bytes. Reset clears the sector
// position and all handshake state at once; there is no clearing pass. A
// stalled output holds the back, and the front stalls only when the queue fills.

module gcr_sector_track_encoder_core import gcrste_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [7:0]  track_number_q;
	logic [7:0]  disk_id_one_q;
	logic [7:0]  disk_id_two_q;
	logic        cfg_write;
	logic        push;
	job_t        push_job;
	logic        pop;
	job_t        head;
	queue_stat_t q_stat;
	back_stat_t  b_stat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_number_q <= TRACK_RESET;
			disk_id_one_q  <= ID_RESET;
			disk_id_two_q  <= ID_RESET;
		end else if (cfg_write) begin
			unique case (paddr[3:2])
				REG_TRACK:  track_number_q <= pwdata[7:0];
				REG_ID_ONE: disk_id_one_q  <= pwdata[7:0];
				REG_ID_TWO: disk_id_two_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[3:2])
			REG_TRACK:  prdata = {24'h0, track_number_q};
			REG_ID_ONE: prdata = {24'h0, disk_id_one_q};
			REG_ID_TWO: prdata = {24'h0, disk_id_two_q};
			default:    prdata = 32'h0;
		endcase
	end

	gcrste_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.track_number (track_number_q),
		.disk_id_one  (disk_id_one_q),
		.disk_id_two  (disk_id_two_q),
		.queue_full   (q_stat.full),
		.push         (push),
		.push_job     (push_job)
	);

	gcrste_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	gcrste_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (q_stat.empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.stat        (b_stat)
	);

	// The queue is never full and empty at once.
	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("job queue full and empty together");

	// Queued work is picked up by an idle back end.
	a_back_pickup: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && !b_stat.busy) |=> b_stat.busy)
		else $error("back end left queued job waiting");

	// A byte sent with the last mark ends the job that was running.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(b_stat.on_last && (!out_valid || out_ready) && q_stat.empty) |=> !b_stat.busy)
		else $error("job kept running past its last byte");

endmodule

`default_nettype wire
